@@ rtl/hsort_pkg.sv @@
package hsort_pkg;

	localparam int DEPTH = 64;
	localparam int KEY_W = 32;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CH_W = ADDR_W + 1;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIGNED = 1'd1;

	typedef struct packed {
		logic [31:0] key_in;
		logic        last_in;
	} hsort_in_t;

	typedef struct packed {
		logic [31:0] key_out;
		logic        last_out;
	} hsort_out_t;

	typedef struct packed {
		logic descending_order;
		logic signed_compare;
	} hsort_cfg_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [KEY_W-1:0]  wdata;
		logic [ADDR_W-1:0] raddr;
	} hsort_mem_req_t;

endpackage

@@ rtl/hsort_mem.sv @@
module hsort_mem import hsort_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [KEY_W-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [KEY_W-1:0]  rdata
);

	logic [KEY_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/hsort_ctrl.sv @@
module hsort_ctrl import hsort_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  hsort_cfg_t     cfg,
	input  logic           start,
	input  hsort_in_t      item,
	output logic           busy,
	output logic           result_strobe,
	output hsort_out_t     result,
	output hsort_mem_req_t mem_req,
	input  logic [KEY_W-1:0] mem_rdata
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_HELD,
		ST_C1,
		ST_C2,
		ST_CMP,
		ST_WB,
		ST_SW0,
		ST_SWI,
		ST_SWC,
		ST_EMIT
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  size_q;
	logic              build_q;
	logic [ADDR_W-1:0] pos_q;
	logic [ADDR_W-1:0] child_q;
	logic [KEY_W-1:0]  held_q;
	logic [KEY_W-1:0]  cval_q;
	logic [KEY_W-1:0]  t0_q;
	logic              emit_s1;
	logic              last_s1;
	logic              strobe_q;
	hsort_out_t        result_q;

	logic [CH_W-1:0]   ch_pos;
	logic [CH_W-1:0]   ch_next;
	logic [CH_W-1:0]   ch_sib;
	logic [CH_W-1:0]   size_x;
	logic              move;
	logic              not_full;
	logic [CNT_W-1:0]  new_cnt;
	logic [CNT_W-1:0]  half_n;

	// True when key a must come after key b in the output order.
	function automatic logic goes_after(logic [KEY_W-1:0] a, logic [KEY_W-1:0] b,
			hsort_cfg_t c);
		logic [KEY_W-1:0] ax;
		logic [KEY_W-1:0] bx;
		ax = a;
		bx = b;
		if (c.signed_compare) begin
			ax[KEY_W-1] = ~a[KEY_W-1];
			bx[KEY_W-1] = ~b[KEY_W-1];
		end
		return c.descending_order ? (ax < bx) : (ax > bx);
	endfunction

	assign ch_pos = {pos_q, 1'b1};
	assign ch_next = {child_q, 1'b1};
	assign ch_sib = CH_W'(child_q) + CH_W'(1);
	assign size_x = CH_W'(size_q);
	assign move = goes_after(cval_q, held_q, cfg);
	assign not_full = (cnt_q < CNT_W'(DEPTH));
	assign new_cnt = not_full ? cnt_q + CNT_W'(1) : cnt_q;
	assign half_n = new_cnt >> 1;

	always_comb begin
		mem_req.we = 1'b0;
		mem_req.waddr = pos_q;
		mem_req.wdata = held_q;
		mem_req.raddr = '0;
		case (state_q)
			ST_IDLE: begin
				mem_req.we = start & ~emit_s1 & not_full;
				mem_req.waddr = cnt_q[ADDR_W-1:0];
				mem_req.wdata = KEY_W'(item.key_in);
			end
			ST_LOAD: mem_req.raddr = pos_q;
			ST_HELD: mem_req.raddr = ch_pos[ADDR_W-1:0];
			ST_C1:   mem_req.raddr = ch_sib[ADDR_W-1:0];
			ST_CMP: begin
				mem_req.we = move;
				mem_req.wdata = cval_q;
				mem_req.raddr = ch_next[ADDR_W-1:0];
			end
			ST_WB:   mem_req.we = 1'b1;
			ST_SWI:  mem_req.raddr = idx_q[ADDR_W-1:0];
			ST_SWC: begin
				mem_req.we = 1'b1;
				mem_req.waddr = idx_q[ADDR_W-1:0];
				mem_req.wdata = t0_q;
				mem_req.raddr = ADDR_W'(1);
			end
			ST_EMIT: mem_req.raddr = idx_q[ADDR_W-1:0];
			default: mem_req.raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			n_q <= '0;
			idx_q <= '0;
			size_q <= '0;
			build_q <= 1'b0;
			pos_q <= '0;
			child_q <= '0;
			emit_s1 <= 1'b0;
			last_s1 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			emit_s1 <= 1'b0;
			strobe_q <= emit_s1;
			if (emit_s1) begin
				result_q.key_out <= mem_rdata[31:0];
				result_q.last_out <= last_s1;
			end
			case (state_q)
				ST_IDLE: begin
					if (start && !emit_s1) begin
						if (item.last_in) begin
							cnt_q <= '0;
							n_q <= new_cnt;
							if (new_cnt > CNT_W'(1)) begin
								size_q <= new_cnt;
								build_q <= 1'b1;
								idx_q <= half_n - CNT_W'(1);
								pos_q <= ADDR_W'(half_n - CNT_W'(1));
								state_q <= ST_LOAD;
							end else begin
								idx_q <= '0;
								state_q <= ST_EMIT;
							end
						end else begin
							cnt_q <= new_cnt;
						end
					end
				end
				ST_LOAD: state_q <= ST_HELD;
				ST_HELD: begin
					held_q <= mem_rdata;
					if (ch_pos < size_x) begin
						child_q <= ch_pos[ADDR_W-1:0];
						state_q <= ST_C1;
					end else begin
						state_q <= ST_WB;
					end
				end
				ST_C1: begin
					cval_q <= mem_rdata;
					state_q <= (ch_sib < size_x) ? ST_C2 : ST_CMP;
				end
				ST_C2: begin
					if (goes_after(mem_rdata, cval_q, cfg)) begin
						cval_q <= mem_rdata;
						child_q <= ch_sib[ADDR_W-1:0];
					end
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (move) begin
						pos_q <= child_q;
						if (ch_next < size_x) begin
							child_q <= ch_next[ADDR_W-1:0];
							state_q <= ST_C1;
						end else begin
							state_q <= ST_WB;
						end
					end else begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					if (build_q) begin
						if (idx_q != '0) begin
							idx_q <= idx_q - CNT_W'(1);
							pos_q <= ADDR_W'(idx_q - CNT_W'(1));
							state_q <= ST_LOAD;
						end else begin
							build_q <= 1'b0;
							idx_q <= n_q - CNT_W'(1);
							state_q <= ST_SW0;
						end
					end else if (idx_q > CNT_W'(1)) begin
						idx_q <= idx_q - CNT_W'(1);
						state_q <= ST_SW0;
					end else begin
						idx_q <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_SW0: state_q <= ST_SWI;
				ST_SWI: begin
					t0_q <= mem_rdata;
					state_q <= ST_SWC;
				end
				ST_SWC: begin
					held_q <= mem_rdata;
					pos_q <= '0;
					size_q <= idx_q;
					if (idx_q > CNT_W'(1)) begin
						child_q <= ADDR_W'(1);
						state_q <= ST_C1;
					end else begin
						state_q <= ST_WB;
					end
				end
				ST_EMIT: begin
					emit_s1 <= 1'b1;
					last_s1 <= (idx_q == n_q - CNT_W'(1));
					if (idx_q == n_q - CNT_W'(1)) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q <= idx_q + CNT_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE) || emit_s1;
	assign result_strobe = strobe_q;
	assign result = result_q;

endmodule

@@ rtl/heap_sort_engine.sv @@
// Channel   Direction  Handshake                  Payload
// item      in         start high, busy low       hsort_in_t (key_in, last_in)
// result    out        result_strobe, one cycle   hsort_out_t (key_out, last_out)
// config    in         cfg_we                     cfg_index, cfg_data
//
// A key that is not marked last is written straight into the key memory. A last beat
// starts the sort: a sift-down from each inner node builds the heap, then the root is
// swapped with the last heap key and sifted down again, bounded by the single read port
// of the key memory. Sorted keys leave one per cycle, read from the key memory and
// registered with result_strobe, and busy falls in the cycle of the last one. Reset
// clears the key count and the configuration; the key memory holds no reset value.
// The receiver cannot stall results.
module heap_sort_engine import hsort_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  hsort_in_t            item,
	output logic                 result_strobe,
	output hsort_out_t           result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic                 cfg_data
);

	hsort_cfg_t       cfg_q;
	hsort_mem_req_t   mem_req;
	logic [KEY_W-1:0] mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DESCENDING: cfg_q.descending_order <= cfg_data;
				CFG_SIGNED:     cfg_q.signed_compare <= cfg_data;
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	hsort_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.start         (start),
		.item          (item),
		.busy          (busy),
		.result_strobe (result_strobe),
		.result        (result),
		.mem_req       (mem_req),
		.mem_rdata     (mem_rdata)
	);

	hsort_mem u_mem (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

endmodule
